@@ rtl/ipd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared widths, register codes, reset values and the configuration struct
// of the incremental PID drive.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

  localparam int IO_W           = 32;   // width of the velocity and drive words
  localparam int COEF_W         = 32;
  localparam int LIMIT_W        = 31;
  localparam int PWM_W          = 16;
  localparam int MUL_W          = 33;   // signed operand width of the shared multiplier
  localparam int PROD_W         = 2 * MUL_W;
  localparam int CFG_IDX_W      = 3;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_FS     = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 32'sd1180;
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -32'sd1835;
  localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 32'sd655;
  localparam logic [LIMIT_W-1:0]       DRV_LIMIT_RST  = 31'd1572864;
  localparam logic [PWM_W-1:0]         PWM_FS_RST     = 16'd999;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_now;
    logic signed [COEF_W-1:0] coef_prev;
    logic signed [COEF_W-1:0] coef_prev2;
    logic [LIMIT_W-1:0]       drive_limit;
    logic [PWM_W-1:0]         pwm_full_scale;
  } ipd_cfg_t;

endpackage

`default_nettype wire

@@ rtl/ipd_cfg.sv @@
// ----------------------------------------------------------------------------
// ipd_cfg
// Configuration register file: coefficients, drive limit and PWM full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [ipd_pkg::COEF_W-1:0]    cfg_wdata,
  output ipd_pkg::ipd_cfg_t            cfg
);
  import ipd_pkg::*;

  ipd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_now       <= COEF_NOW_RST;
      cfg_r.coef_prev      <= COEF_PREV_RST;
      cfg_r.coef_prev2     <= COEF_PREV2_RST;
      cfg_r.drive_limit    <= DRV_LIMIT_RST;
      cfg_r.pwm_full_scale <= PWM_FS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_NOW:   cfg_r.coef_now       <= $signed(cfg_wdata);
        REG_COEF_PREV:  cfg_r.coef_prev      <= $signed(cfg_wdata);
        REG_COEF_PREV2: cfg_r.coef_prev2     <= $signed(cfg_wdata);
        REG_DRV_LIMIT:  cfg_r.drive_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_PWM_FS:     cfg_r.pwm_full_scale <= cfg_wdata[PWM_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/ipd_mul.sv @@
// ----------------------------------------------------------------------------
// ipd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_mul (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire signed [ipd_pkg::MUL_W-1:0]       a,
  input  wire signed [ipd_pkg::MUL_W-1:0]       b,
  output logic signed [ipd_pkg::PROD_W-1:0]     prod
);
  import ipd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ rtl/ipd_div.sv @@
// ----------------------------------------------------------------------------
// ipd_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// The caller keeps the dividend below divisor * 2^16.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_div #(
  parameter int FRAC_BITS = ipd_pkg::FRAC_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        start,
  input  wire [ipd_pkg::LIMIT_W-FRAC_BITS+ipd_pkg::PWM_W-1:0] dividend,
  input  wire [ipd_pkg::LIMIT_W-FRAC_BITS-1:0]       divisor,
  output logic                                       done,
  output logic [ipd_pkg::PWM_W-1:0]                  quot
);
  import ipd_pkg::*;

  localparam int LINTW = LIMIT_W - FRAC_BITS;
  localparam int DVW   = LINTW + PWM_W;
  localparam int CNT_W = $clog2(PWM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVW-1:0]   rem_r;
  logic [DVW-1:0]   den_r;
  logic [PWM_W-1:0] quot_r;
  logic             ge;

  assign ge = (rem_r >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PWM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      den_r  <= DVW'(divisor) << (PWM_W - 1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      den_r  <= den_r >> 1;
      quot_r <= {quot_r[PWM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

@@ rtl/incremental_pid_pwm_drive.sv @@
// ----------------------------------------------------------------------------
// incremental_pid_pwm_drive
// Velocity-form PID tick with drive accumulator, clamp and PWM scaling.
// The 16-step PWM divider takes most of the time from word accepted to result valid.
// Input: a new word is taken only in the idle state, once the last result is
//   loaded out; a stalled result word holds off the next input.
//   The three filter products and the PWM product share a single multiplier.
// Reset: synchronous active-low, clears filter history, drive and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_pwm_drive #(
  parameter int DATA_WIDTH = ipd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ipd_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [ipd_pkg::IO_W-1:0]   in_target_velocity,
  input  wire signed [ipd_pkg::IO_W-1:0]   in_outer_correction,
  input  wire signed [ipd_pkg::IO_W-1:0]   in_measured_velocity,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [ipd_pkg::IO_W-1:0]  out_drive_level,
  output logic [ipd_pkg::PWM_W-1:0]        out_pwm_compare,
  output logic                             out_reverse,
  output logic                             out_clamped,
  input  wire                              cfg_we,
  input  wire [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [ipd_pkg::COEF_W-1:0]        cfg_wdata
);
  import ipd_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int DW1   = DW + 1;
  localparam int NP    = (DW > 32) ? 2 : 1;          // multiplier passes per term
  localparam int AW    = DW + 35;                    // exact sum of three products
  localparam int EW    = ((DW > IO_W + 2) ? DW : IO_W + 2) + 1;
  localparam int LCW   = ((DW > LIMIT_W) ? DW : LIMIT_W) + 1;
  localparam int LINTW = LIMIT_W - FRAC_BITS;
  localparam int DVW   = LINTW + PWM_W;

  localparam logic signed [EW-1:0] EMAX = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = ~EMAX;
  localparam logic signed [AW-1:0] AMAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] AMIN = ~AMAX;
  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [LCW-1:0]       WMAX_U = {{(LCW-DW+1){1'b0}}, {(DW-1){1'b1}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_FILT  = 4'd3;
  localparam logic [3:0] S_DRV   = 4'd4;
  localparam logic [3:0] S_PMUL  = 4'd5;
  localparam logic [3:0] S_PLOAD = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] TERM_NOW   = 2'd0;
  localparam logic [1:0] TERM_PREV  = 2'd1;
  localparam logic [1:0] TERM_PREV2 = 2'd2;

  ipd_cfg_t cfg;

  logic [3:0]              state_r, state_nxt;
  logic [1:0]              term_r;
  logic                    pass_r;
  logic                    issue_v_r;
  logic                    issue_hi_r;
  logic signed [DW-1:0]    e_r, e1_r, e2_r, y1_r, drive_r, yv_r;
  logic signed [AW-1:0]    sacc_r;
  logic                    clmp_r;
  logic                    out_valid_r;
  logic signed [IO_W-1:0]  out_drive_r;
  logic [PWM_W-1:0]        out_pwm_r;
  logic                    out_rev_r;
  logic                    out_clmp_r;

  logic                    in_acc;
  logic                    last_pass;
  logic                    out_load;
  logic signed [EW-1:0]    esum;
  logic signed [DW-1:0]    e_nxt;
  logic signed [DW-1:0]    e_src;
  logic signed [63:0]      e_ext;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic                    mul_en;
  logic signed [PROD_W-1:0] prod;
  logic signed [AW-1:0]    addend;
  logic signed [AW-1:0]    fsum;
  logic signed [DW-1:0]    y_nxt;
  logic [LCW-1:0]          dl_u, lim_u;
  logic signed [DW1-1:0]   limd, dsum;
  logic signed [DW-1:0]    drv_nxt;
  logic                    clmp_nxt;
  logic [DW-1:0]           abs_u;
  logic [LINTW-1:0]        mag;
  logic [LINTW-1:0]        lint;
  logic                    div_start, div_done;
  logic [PWM_W-1:0]        quot;

  ipd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ipd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[DVW-1:0]),
    .divisor  (lint),
    .done     (div_done),
    .quot     (quot)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign last_pass = (NP == 1) || pass_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign mul_en    = (state_r == S_MAC) || (state_r == S_PMUL);
  assign div_start = (state_r == S_PLOAD);
  assign lint      = cfg.drive_limit[LIMIT_W-1:FRAC_BITS];

  // error, saturated to the data word
  always_comb begin
    esum = EW'(in_target_velocity) + EW'(in_outer_correction)
         - EW'(in_measured_velocity);
    if (esum > EMAX) begin
      e_nxt = WMAX;
    end else if (esum < EMIN) begin
      e_nxt = WMIN;
    end else begin
      e_nxt = DW'(esum);
    end
  end

  // multiplier operands: coefficient times one chunk of the error history, or PWM full scale times the drive magnitude
  always_comb begin
    case (term_r)
      TERM_NOW:  e_src = e_r;
      TERM_PREV: e_src = e1_r;
      default:   e_src = e2_r;
    endcase
    e_ext = 64'(e_src);
    if (state_r == S_PMUL) begin
      mul_a = {{(MUL_W-PWM_W){1'b0}}, cfg.pwm_full_scale};
      mul_b = {{(MUL_W-LINTW){1'b0}}, mag};
    end else begin
      case (term_r)
        TERM_NOW:  mul_a = MUL_W'(cfg.coef_now);
        TERM_PREV: mul_a = MUL_W'(cfg.coef_prev);
        default:   mul_a = MUL_W'(cfg.coef_prev2);
      endcase
      if (pass_r) begin
        mul_b = {e_ext[63], e_ext[63:32]};
      end else if (NP == 1) begin
        mul_b = {e_ext[32], e_ext[31:0]};
      end else begin
        mul_b = {1'b0, e_ext[31:0]};
      end
    end
  end

  // upper chunk lands 32 bits up; the sum wraps modulo 2^AW and ends exact
  always_comb begin
    if (issue_hi_r) begin
      addend = AW'({prod, 32'b0});
    end else begin
      addend = AW'(prod);
    end
  end

  // filter output: floor of the sum by 2^F, plus last output, saturated
  always_comb begin
    fsum = (sacc_r >>> FRAC_BITS) + AW'(y1_r);
    if (fsum > AMAX) begin
      y_nxt = WMAX;
    end else if (fsum < AMIN) begin
      y_nxt = WMIN;
    end else begin
      y_nxt = DW'(fsum);
    end
  end

  // drive accumulator with clamp to the smaller of the limit and the word max
  always_comb begin
    dl_u  = LCW'(cfg.drive_limit);
    lim_u = (dl_u < WMAX_U) ? dl_u : WMAX_U;
    limd  = $signed(DW1'(lim_u));
    dsum  = DW1'(drive_r) + DW1'(yv_r);
    clmp_nxt = 1'b1;
    if (dsum > limd) begin
      drv_nxt = DW'(limd);
    end else if (dsum < -limd) begin
      drv_nxt = DW'(-limd);
    end else begin
      drv_nxt  = DW'(dsum);
      clmp_nxt = 1'b0;
    end
  end

  // |trunc(drive / 2^F)| equals floor(|drive| / 2^F)
  always_comb begin
    abs_u = drive_r[DW-1] ? DW'(-drive_r) : drive_r;
    mag   = LINTW'(abs_u >> FRAC_BITS);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MAC;
      S_MAC:   if (last_pass && term_r == TERM_PREV2) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FILT;
      S_FILT:  state_nxt = S_DRV;
      S_DRV:   state_nxt = S_PMUL;
      S_PMUL:  state_nxt = S_PLOAD;
      S_PLOAD: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= TERM_NOW;
      pass_r      <= 1'b0;
      issue_v_r   <= 1'b0;
      issue_hi_r  <= 1'b0;
      e1_r        <= '0;
      e2_r        <= '0;
      y1_r        <= '0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      issue_v_r  <= (state_r == S_MAC);
      issue_hi_r <= pass_r;
      if (in_acc) begin
        term_r <= TERM_NOW;
        pass_r <= 1'b0;
      end else if (state_r == S_MAC) begin
        if (last_pass) begin
          pass_r <= 1'b0;
          term_r <= term_r + 2'd1;
        end else begin
          pass_r <= 1'b1;
        end
      end
      if (state_r == S_DRV) begin
        e2_r    <= e1_r;
        e1_r    <= e_r;
        y1_r    <= yv_r;
        drive_r <= drv_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r    <= e_nxt;
      sacc_r <= '0;
    end else if (issue_v_r) begin
      sacc_r <= sacc_r + addend;
    end
    if (state_r == S_FILT) begin
      yv_r <= y_nxt;
    end
    if (state_r == S_DRV) begin
      clmp_r <= clmp_nxt;
    end
    if (out_load) begin
      out_drive_r <= IO_W'(drive_r);
      out_pwm_r   <= (lint == '0) ? '0 : quot;
      out_rev_r   <= !(drive_r > 0);
      out_clmp_r  <= clmp_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_level = out_drive_r;
  assign out_pwm_compare = out_pwm_r;
  assign out_reverse     = out_rev_r;
  assign out_clamped     = out_clmp_r;

endmodule

`default_nettype wire
